[rtl/core/bvs_pkg.sv]
// Package for the bit vector set engine: field widths, operation codes,
// sequencer states and parameter defaults. No dependencies.
package bvs_pkg;

   localparam int LEN_W  = 9;
   localparam int FUNC_W = 4;
   localparam int VSEL_W = 3;
   localparam int BIDX_W = 8;

   localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

   localparam int DEF_NUM_VECTORS = 8;
   localparam int DEF_MAX_BITS    = 256;
   localparam int DEF_WORD_BITS   = 32;

   typedef enum logic [FUNC_W-1:0] {
      FN_SET       = 4'd0,
      FN_CLEAR     = 4'd1,
      FN_TEST      = 4'd2,
      FN_FIND      = 4'd3,
      FN_AND       = 4'd4,
      FN_OR        = 4'd5,
      FN_XOR       = 4'd6,
      FN_ANDNOT    = 4'd7,
      FN_COPY      = 4'd8,
      FN_CLEAR_ALL = 4'd9,
      FN_SET_ALL   = 4'd10,
      FN_EQUAL     = 4'd11,
      FN_DISJOINT  = 4'd12
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_FINISH
   } state_type;

endpackage

[rtl/core/bit_vector_set_engine.sv]
// Bit vector set engine top level: word-serial sequencer over the vector RAM.
// Depends on bvs_pkg and bvs_ram.
//
// Usage:
//   req_* carries one operation per beat (valid/ready). rsp_* returns one
//   result beat per request, in order. csr_* writes vector_length; write it
//   only while no request is outstanding.
//   Every operation walks the vector one stored word per cycle: WPV words,
//   WPV = ceil(MAX_BITS / WORD_BITS), read from the RAM on two read ports;
//   operations that change a vector write each word back in the cycle after
//   its read, on the single write port. Each request runs the scan, flush
//   and finish states in order; its result beat enters the output register
//   from finish in the same cycle the next one is taken; no two overlap.
//   Reset: a clearing pass zeroes all NUM_VECTORS * WPV RAM words (64 at the
//   defaults), one word per cycle; req_ready stays low until it ends.
//   vector_length returns to 256.
//   Receiver stall: the output register holds its beat; a finished operation
//   waits in place and req_ready stays low until the register frees.
module bit_vector_set_engine
   import bvs_pkg::*;
#(
   parameter int NUM_VECTORS = DEF_NUM_VECTORS,
   parameter int MAX_BITS    = DEF_MAX_BITS,
   parameter int WORD_BITS   = DEF_WORD_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [VSEL_W-1:0] req_target_vector,
   input  logic [VSEL_W-1:0] req_first_source,
   input  logic [VSEL_W-1:0] req_second_source,
   input  logic [BIDX_W-1:0] req_bit_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_flag,
   output logic [LEN_W-1:0]  rsp_found_index,
   output logic              rsp_range_error,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LEN_W-1:0]  csr_vector_length
);

   localparam int WPV     = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH   = NUM_VECTORS * WPV;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int WIDX_W  = (WPV > 1) ? $clog2(WPV) : 1;
   localparam int POS_W   = $clog2(WPV * WORD_BITS + 1);
   localparam int LO_W    = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int WPOS_W  = $clog2(WORD_BITS);
   localparam logic [WIDX_W-1:0] W_LAST   = WIDX_W'(WPV - 1);
   localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] vec_base(input logic [VSEL_W-1:0] sel);
      logic [VSEL_W-1:0] v;
      v = sel;
      for (int i = 0; i < (1 << VSEL_W); i++) begin
         if (int'(v) >= NUM_VECTORS) begin
            v = v - VSEL_W'(NUM_VECTORS);
         end
      end
      return ADDR_W'(v) * ADDR_W'(WPV);
   endfunction

   state_type state_ff, state_in;

   logic [LEN_W-1:0]     len_ff;
   logic [ADDR_W-1:0]    clr_ff;
   func_type             func_ff;
   logic [ADDR_W-1:0]    tbase_ff, abase_ff, bbase_ff;
   logic [BIDX_W-1:0]    bidx_ff;
   logic                 err_ff;
   logic [WIDX_W-1:0]    w_ff, wd_ff;
   logic [LO_W-1:0]      lo_ff, lo_d_ff;
   logic                 proc_ff;
   logic                 flag_ff;
   logic                 found_hit_ff;
   logic [LEN_W-1:0]     found_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_flag_ff;
   logic [LEN_W-1:0]     rsp_found_ff;
   logic                 rsp_err_ff;

   logic                 accept, out_free, rsp_load, scan;
   func_type             req_fn;
   logic                 req_whole;
   logic [LO_W-1:0]      n_eff;
   logic [WORD_BITS-1:0] rd_a, rd_b;
   logic [WORD_BITS-1:0] vmask, geb, hit, cand, whole_r;
   logic [WPOS_W-1:0]    pe;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // effective length, clamped to [1, MAX_BITS]
   always_comb begin
      if (len_ff == '0) begin
         n_eff = LO_W'(1);
      end else if (LO_W'(len_ff) > LO_W'(MAX_BITS)) begin
         n_eff = LO_W'(MAX_BITS);
      end else begin
         n_eff = LO_W'(len_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign req_fn    = func_type'(req_func);
   assign req_whole = (req_func >= FN_AND) && (req_func <= FN_SET_ALL);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == ADDR_END) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (w_ff == W_LAST) state_in = ST_FLUSH;
         ST_FLUSH:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = req_valid ? ST_SCAN : ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      scan      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan = 1'b1;
         ST_FINISH: begin
            req_ready = out_free;
            rsp_load  = out_free;
         end
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         len_ff       <= LEN_RESET;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         proc_ff  <= scan;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + ADDR_W'(1);
         if (csr_valid) len_ff <= csr_vector_length;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture and word walk
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_fn;
         bidx_ff  <= req_bit_index;
         err_ff   <= (req_func <= FN_TEST) && (LO_W'(req_bit_index) >= n_eff);
         tbase_ff <= vec_base(req_target_vector);
         abase_ff <= req_whole ? vec_base(req_first_source) : vec_base(req_target_vector);
         bbase_ff <= req_whole ? vec_base(req_second_source) : vec_base(req_first_source);
         w_ff     <= '0;
         lo_ff    <= '0;
      end else if (scan) begin
         w_ff  <= w_ff + WIDX_W'(1);
         lo_ff <= lo_ff + LO_W'(WORD_BITS);
      end
      wd_ff   <= w_ff;
      lo_d_ff <= lo_ff;
   end

   bvs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (abase_ff + ADDR_W'(w_ff)),
      .rd_addr_b (bbase_ff + ADDR_W'(w_ff)),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // per-word masks on the word returned by the RAM
   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         vmask[j] = (lo_d_ff + LO_W'(j)) <  n_eff;
         geb[j]   = (lo_d_ff + LO_W'(j)) >= LO_W'(bidx_ff);
         hit[j]   = (lo_d_ff + LO_W'(j)) == LO_W'(bidx_ff);
      end
      cand = rd_a & vmask & geb;
      pe   = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (cand[j]) pe = WPOS_W'(j);
      end
      case (func_ff)
         FN_AND:       whole_r = rd_a & rd_b;
         FN_OR:        whole_r = rd_a | rd_b;
         FN_XOR:       whole_r = rd_a ^ rd_b;
         FN_ANDNOT:    whole_r = rd_a & ~rd_b;
         FN_CLEAR_ALL: whole_r = '0;
         FN_SET_ALL:   whole_r = '1;
         default:      whole_r = rd_a;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tbase_ff + ADDR_W'(wd_ff);
      wr_data = rd_a;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (proc_ff) begin
         case (func_ff) inside
            FN_SET: begin
               wr_en   = !err_ff && (|hit);
               wr_data = rd_a | hit;
            end
            FN_CLEAR: begin
               wr_en   = !err_ff && (|hit);
               wr_data = rd_a & ~hit;
            end
            FN_AND, FN_OR, FN_XOR, FN_ANDNOT, FN_COPY, FN_CLEAR_ALL, FN_SET_ALL: begin
               wr_en   = 1'b1;
               wr_data = whole_r & vmask;
            end
            default: ;
         endcase
      end
   end

   // accumulate test, search and compare results
   always_ff @(posedge clock) begin
      if (accept) begin
         flag_ff      <= (req_func == FN_EQUAL) || (req_func == FN_DISJOINT);
         found_hit_ff <= 1'b0;
      end else if (proc_ff) begin
         case (func_ff)
            FN_TEST: begin
               if (!err_ff && (|(rd_a & hit))) flag_ff <= 1'b1;
            end
            FN_FIND: begin
               if (!found_hit_ff && (|cand)) begin
                  found_hit_ff <= 1'b1;
                  found_ff     <= LEN_W'(lo_d_ff + LO_W'(pe));
               end
            end
            FN_EQUAL: begin
               if (|((rd_a ^ rd_b) & vmask)) flag_ff <= 1'b0;
            end
            FN_DISJOINT: begin
               if (|(rd_a & rd_b & vmask)) flag_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_flag_ff <= flag_ff;
         rsp_err_ff  <= err_ff;
         if (func_ff == FN_FIND) begin
            rsp_found_ff <= found_hit_ff ? found_ff : LEN_W'(n_eff);
         end else begin
            rsp_found_ff <= '0;
         end
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_flag        = rsp_flag_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

[rtl/core/bvs_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module bvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[rtl/core/bvs_checker.sv]
// Port-level checker for the bit vector set engine, bound to the top level.
// Depends on bvs_pkg.
module bvs_checker
   import bvs_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_flag,
   input logic [LEN_W-1:0]  rsp_found_index,
   input logic              rsp_range_error
);

   // req_ready and rsp_valid are low right after reset, as the clearing pass starts
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("request taken during clearing pass");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flag)
         && $stable(rsp_found_index) && $stable(rsp_range_error))
      else $error("result beat changed under stall");

   // a range error carries no other result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> !rsp_flag && rsp_found_index == '0)
      else $error("range error with other result fields set");

   // a set flag comes from test or compare, never with a search result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flag |-> rsp_found_index == '0)
      else $error("flag and found index both set");

endmodule

bind bit_vector_set_engine bvs_checker u_bvs_checker (.*);

[bench/bit_vector_set_engine_tb.sv]
// Testbench for bit_vector_set_engine: a directed table, then random operations checked
// against a bit-level model of the vector bank, under random sender and receiver pacing.
// Depends on bvs_pkg and the engine RTL.
module bit_vector_set_engine_tb
   import bvs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NVEC = 8;
   localparam int NBITS = 256;
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd13;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;
   localparam int RANDOM_STEPS = 450;
   localparam int PHASE_STEPS = 60;

   typedef struct packed {
      logic              cfg_write;
      logic [LEN_W-1:0]  cfg_len;
      logic [FUNC_W-1:0] func;
      logic [VSEL_W-1:0] tgt;
      logic [VSEL_W-1:0] src1;
      logic [VSEL_W-1:0] src2;
      logic [BIDX_W-1:0] idx;
      logic              typed;
      logic              flag;
      logic [LEN_W-1:0]  found;
      logic              err;
   } step_row_type;

   typedef struct packed {
      logic             flag;
      logic [LEN_W-1:0] found;
      logic             err;
   } bitset_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [FUNC_W-1:0] req_func;
   logic [VSEL_W-1:0] req_target_vector;
   logic [VSEL_W-1:0] req_first_source;
   logic [VSEL_W-1:0] req_second_source;
   logic [BIDX_W-1:0] req_bit_index;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_flag;
   logic [LEN_W-1:0]  rsp_found_index;
   logic              rsp_range_error;
   logic              csr_valid;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_vector_length;

   logic [NBITS-1:0]  vector_bank [NVEC];
   logic [LEN_W-1:0]  length_reg;
   bitset_result_type pending_results [$];
   bitset_result_type head_result;
   int                errors = 0;
   int                results_seen = 0;
   int                burst_left = 0;

   step_row_type directed_rows [25] = '{
      '{1'b0, 9'd0,   FN_FIND,      3'd0, 3'd0, 3'd0, 8'd0,   1'b1, 1'b0, 9'd256, 1'b0},
      '{1'b0, 9'd0,   FN_TEST,      3'd7, 3'd0, 3'd0, 8'd255, 1'b1, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_SET,       3'd0, 3'd0, 3'd0, 8'd0,   1'b1, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_SET,       3'd0, 3'd0, 3'd0, 8'd255, 1'b1, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_FIND,      3'd0, 3'd0, 3'd0, 8'd1,   1'b1, 1'b0, 9'd255, 1'b0},
      '{1'b0, 9'd0,   FN_TEST,      3'd0, 3'd0, 3'd0, 8'd255, 1'b1, 1'b1, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_SET_ALL,   3'd1, 3'd0, 3'd0, 8'd0,   1'b1, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_XOR,       3'd2, 3'd1, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_AND,       3'd3, 3'd1, 3'd2, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_OR,        3'd4, 3'd0, 3'd3, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_ANDNOT,    3'd5, 3'd1, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_COPY,      3'd6, 3'd5, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_EQUAL,     3'd6, 3'd5, 3'd0, 8'd0,   1'b1, 1'b1, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_DISJOINT,  3'd0, 3'd5, 3'd0, 8'd0,   1'b1, 1'b1, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_CLEAR,     3'd1, 3'd0, 3'd0, 8'd100, 1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_EQUAL,     3'd1, 3'd6, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_CLEAR_ALL, 3'd4, 3'd0, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_SPARE_LO,  3'd7, 3'd7, 3'd7, 8'd255, 1'b1, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_SPARE_HI,  3'd1, 3'd2, 3'd3, 8'd5,   1'b1, 1'b0, 9'd0,   1'b0},
      '{1'b1, 9'd100, FN_SET,       3'd0, 3'd0, 3'd0, 8'd100, 1'b1, 1'b0, 9'd0,   1'b1},
      '{1'b0, 9'd0,   FN_TEST,      3'd0, 3'd0, 3'd0, 8'd200, 1'b1, 1'b0, 9'd0,   1'b1},
      '{1'b0, 9'd0,   FN_FIND,      3'd1, 3'd0, 3'd0, 8'd150, 1'b1, 1'b0, 9'd100, 1'b0},
      '{1'b1, 9'd0,   FN_SET_ALL,   3'd7, 3'd0, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b0, 9'd0,   FN_FIND,      3'd7, 3'd0, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0},
      '{1'b1, 9'd511, FN_EQUAL,     3'd7, 3'd0, 3'd0, 8'd0,   1'b0, 1'b0, 9'd0,   1'b0}
   };

   bit_vector_set_engine uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_target_vector (req_target_vector),
      .req_first_source  (req_first_source),
      .req_second_source (req_second_source),
      .req_bit_index     (req_bit_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_flag          (rsp_flag),
      .rsp_found_index   (rsp_found_index),
      .rsp_range_error   (rsp_range_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_vector_length (csr_vector_length)
   );

   always #4 clock = ~clock;

   function automatic int unsigned active_len();
      if (length_reg == '0) return 1;
      if (length_reg > NBITS) return NBITS;
      return length_reg;
   endfunction

   function automatic bitset_result_type bitset_apply(input step_row_type row);
      bitset_result_type res;
      int unsigned       n;
      logic [NBITS-1:0]  keep;
      logic [NBITS-1:0]  a;
      logic [NBITS-1:0]  c;
      logic [NBITS-1:0]  r;
      res = '0;
      n = active_len();
      keep = {NBITS{1'b1}} >> (NBITS - n);
      a = vector_bank[row.src1];
      c = vector_bank[row.src2];
      r = '0;
      case (row.func)
         FN_SET, FN_CLEAR, FN_TEST: begin
            if (row.idx >= n) begin
               res.err = 1'b1;
            end else begin
               case (row.func)
                  FN_SET:   vector_bank[row.tgt][row.idx] = 1'b1;
                  FN_CLEAR: vector_bank[row.tgt][row.idx] = 1'b0;
                  default:  res.flag = vector_bank[row.tgt][row.idx];
               endcase
            end
         end
         FN_FIND: begin
            res.found = LEN_W'(n);
            for (int unsigned i = row.idx; i < n; i++) begin
               if (vector_bank[row.tgt][i]) begin
                  res.found = LEN_W'(i);
                  break;
               end
            end
         end
         FN_AND, FN_OR, FN_XOR, FN_ANDNOT, FN_COPY, FN_CLEAR_ALL, FN_SET_ALL: begin
            case (row.func)
               FN_AND:       r = a & c;
               FN_OR:        r = a | c;
               FN_XOR:       r = a ^ c;
               FN_ANDNOT:    r = a & ~c;
               FN_COPY:      r = a;
               FN_CLEAR_ALL: r = '0;
               default:      r = {NBITS{1'b1}};
            endcase
            vector_bank[row.tgt] = r & keep;
         end
         FN_EQUAL:    res.flag = ((vector_bank[row.tgt] & keep) == (a & keep));
         FN_DISJOINT: res.flag = ((vector_bank[row.tgt] & a & keep) == '0);
         default: ;
      endcase
      return res;
   endfunction

   function automatic step_row_type random_row();
      step_row_type row;
      int unsigned  pick;
      int unsigned  top;
      row = '0;
      pick = $urandom_range(0, 99);
      if (pick < 25)      row.func = FN_SET;
      else if (pick < 33) row.func = FN_CLEAR;
      else if (pick < 43) row.func = FN_TEST;
      else if (pick < 55) row.func = FN_FIND;
      else if (pick < 85) row.func = FUNC_W'($urandom_range(FN_AND, FN_SET_ALL));
      else if (pick < 96) row.func = ($urandom_range(0, 1) != 0) ? FN_EQUAL : FN_DISJOINT;
      else                row.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      row.tgt = VSEL_W'($urandom_range(0, NVEC - 1));
      row.src1 = VSEL_W'($urandom_range(0, NVEC - 1));
      row.src2 = VSEL_W'($urandom_range(0, NVEC - 1));
      top = active_len() - 1;
      if (top > 255) top = 255;
      if ($urandom_range(0, 9) < 7) row.idx = BIDX_W'($urandom_range(0, top));
      else                          row.idx = BIDX_W'($urandom_range(0, 255));
      return row;
   endfunction

   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic offer_step(input step_row_type row);
      bitset_result_type predicted;
      @(negedge clock);
      req_valid = 1'b1;
      req_func = row.func;
      req_target_vector = row.tgt;
      req_first_source = row.src1;
      req_second_source = row.src2;
      req_bit_index = row.idx;
      do @(posedge clock); while (!req_ready);
      predicted = bitset_apply(row);
      if (row.typed) pending_results.push_back({row.flag, row.found, row.err});
      else           pending_results.push_back(predicted);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_vector_length = value;
      do @(posedge clock); while (!csr_ready);
      length_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
      burst_left = 0;
   endtask

   function automatic logic [LEN_W-1:0] phase_length(input int phase);
      case (phase % 8)
         0: return 9'd1;
         1: return 9'd0;
         2: return 9'd511;
         3: return 9'd37;
         4: return 9'd257;
         5: return 9'd255;
         6: return 9'd128;
         default: return LEN_W'($urandom_range(1, 300));
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result beat with no operation outstanding");
            errors++;
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_flag !== head_result.flag) begin
               $error("flag: expected %0d, got %0d", head_result.flag, rsp_flag);
               errors++;
            end
            if (rsp_found_index !== head_result.found) begin
               $error("found_index: expected %0d, got %0d", head_result.found, rsp_found_index);
               errors++;
            end
            if (rsp_range_error !== head_result.err) begin
               $error("range_error: expected %0d, got %0d", head_result.err, rsp_range_error);
               errors++;
            end
         end
      end
   end

   initial begin
      int unsigned mode;
      int unsigned span;
      int          holds_done;
      holds_done = 0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 80);
         repeat (span) begin
            @(negedge clock);
            if ((holds_done == 0 && results_seen >= 150) ||
                (holds_done == 1 && results_seen >= 320)) begin
               rsp_ready = 1'b0;
               repeat (300) @(negedge clock);
               holds_done++;
            end
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 1) != 0);
               2: rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = ~rsp_ready;
            endcase
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_target_vector = '0;
      req_first_source = '0;
      req_second_source = '0;
      req_bit_index = '0;
      csr_valid = 1'b0;
      csr_vector_length = '0;
      length_reg = LEN_RESET;
      foreach (vector_bank[v]) vector_bank[v] = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].cfg_write) write_length(directed_rows[k].cfg_len);
         pace_sender();
         offer_step(directed_rows[k]);
      end

      for (int k = 0; k < RANDOM_STEPS; k++) begin
         if (k % PHASE_STEPS == 0) write_length(phase_length(k / PHASE_STEPS));
         pace_sender();
         offer_step(random_row());
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
rtl/core/bvs_pkg.sv
rtl/core/bvs_ram.sv
rtl/core/bit_vector_set_engine.sv
rtl/core/bvs_checker.sv
bench/bit_vector_set_engine_tb.sv
